// ===== hw/rtl/tlvp_pkg.sv =====
// shared types, codes and constants of the typed parameter stream parser
package tlvp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_payload;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  field_kind;
		logic [63:0] field_value;
		logic [3:0]  field_slot;
		logic [15:0] string_offset;
		logic [15:0] string_length;
		logic [2:0]  status;
		logic        final_res;
	} field_item_t;

	localparam int unsigned DEF_MAX_PER_KIND  = 16;
	localparam int unsigned MAX_PAYLOAD_BYTES = 65536;
	localparam int unsigned NUM_KINDS         = 5;

	// field kinds
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_INT    = 3'd1;
	localparam logic [2:0] KIND_FLOAT  = 3'd2;
	localparam logic [2:0] KIND_DOUBLE = 3'd3;
	localparam logic [2:0] KIND_STRING = 3'd4;
	localparam logic [2:0] KIND_PTR    = 3'd5;
	localparam logic [2:0] KIND_BLOB   = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNCATED = 3'd1;
	localparam logic [2:0] ST_BAD_TAG   = 3'd2;
	localparam logic [2:0] ST_BAD_PTR   = 3'd3;
	localparam logic [2:0] ST_TOO_MANY  = 3'd4;
	localparam logic [2:0] ST_TOO_LONG  = 3'd5;

	// type tags (ascii)
	localparam logic [7:0] TAG_INT    = 8'h69;
	localparam logic [7:0] TAG_FLOAT  = 8'h66;
	localparam logic [7:0] TAG_DOUBLE = 8'h64;
	localparam logic [7:0] TAG_STRING = 8'h73;
	localparam logic [7:0] TAG_PTR    = 8'h70;
	localparam logic [7:0] TAG_BLOB   = 8'h62;

	// accepted pointer windows, upper bounds exclusive
	localparam logic [31:0] PTR_A_LO = 32'h8000_0000;
	localparam logic [31:0] PTR_A_HI = 32'h8180_0000;
	localparam logic [31:0] PTR_B_LO = 32'h9000_0000;
	localparam logic [31:0] PTR_B_HI = 32'h9400_0000;

	// counter slot of a counted kind
	function automatic logic [2:0] kind_index(input logic [2:0] kind);
		logic [2:0] idx;
		case (kind)
			KIND_INT:    idx = 3'd0;
			KIND_FLOAT:  idx = 3'd1;
			KIND_DOUBLE: idx = 3'd2;
			KIND_STRING: idx = 3'd3;
			KIND_PTR:    idx = 3'd4;
			default:     idx = 3'd0;
		endcase
		return idx;
	endfunction

endpackage

// ===== hw/rtl/tlvp_in_stage.sv =====
// input register stage holding one accepted payload byte
module tlvp_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  tlvp_pkg::byte_item_t  byte_item,
	input  logic                  take,
	output logic                  valid_s1,
	output tlvp_pkg::byte_item_t  item_s1
);

	// room when empty or when the held byte moves on this cycle
	assign byte_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

endmodule

// ===== hw/rtl/tlvp_parser.sv =====
// parse state and single-pass decode of one byte into at most one result
module tlvp_parser #(
	parameter int unsigned MAX_PER_KIND = tlvp_pkg::DEF_MAX_PER_KIND
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  tlvp_pkg::byte_item_t   item,
	output tlvp_pkg::field_item_t  result,
	output logic                   have
);

	localparam int unsigned CNT_W = $clog2(MAX_PER_KIND + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PER_KIND);
	localparam logic [15:0] LAST_POS = 16'(tlvp_pkg::MAX_PAYLOAD_BYTES - 1);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_VALUE,
		PH_BODY
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [2:0]       kind_q, kind_n;
	logic [63:0]      acc_q, acc_n;
	logic [15:0]      rem_q, rem_n;
	logic [15:0]      pos_q, pos_n;
	logic [15:0]      sstart_q, sstart_n;
	logic [CNT_W-1:0] cnt_q [tlvp_pkg::NUM_KINDS];
	logic [CNT_W-1:0] cnt_n [tlvp_pkg::NUM_KINDS];
	logic             err_q, err_n;

	logic             do_finish;
	logic             ptr_ok;
	logic [2:0]       kidx;
	logic [CNT_W-1:0] slot;
	logic [7:0]       b;

	function automatic tlvp_pkg::field_item_t status_only(input logic [2:0] st);
		tlvp_pkg::field_item_t r;
		r = '0;
		r.status = st;
		r.final_res = 1'b1;
		return r;
	endfunction

	assign b = item.data_byte;
	assign kidx = tlvp_pkg::kind_index(kind_q);
	assign slot = cnt_q[kidx];

	always_comb begin
		phase_n = phase_q;
		kind_n = kind_q;
		acc_n = acc_q;
		rem_n = rem_q;
		sstart_n = sstart_q;
		cnt_n = cnt_q;
		err_n = err_q;
		pos_n = pos_q + 16'd1;
		result = '0;
		have = 1'b0;
		do_finish = 1'b0;
		ptr_ok = 1'b0;

		if (!err_q) begin
			unique case (phase_q)
				PH_TAG: begin
					acc_n = '0;
					case (b)
						tlvp_pkg::TAG_INT: begin
							kind_n = tlvp_pkg::KIND_INT;
							rem_n = 16'd4;
							phase_n = PH_VALUE;
						end
						tlvp_pkg::TAG_FLOAT: begin
							kind_n = tlvp_pkg::KIND_FLOAT;
							rem_n = 16'd4;
							phase_n = PH_VALUE;
						end
						tlvp_pkg::TAG_DOUBLE: begin
							kind_n = tlvp_pkg::KIND_DOUBLE;
							rem_n = 16'd8;
							phase_n = PH_VALUE;
						end
						tlvp_pkg::TAG_PTR: begin
							kind_n = tlvp_pkg::KIND_PTR;
							rem_n = 16'd4;
							phase_n = PH_VALUE;
						end
						tlvp_pkg::TAG_STRING: begin
							kind_n = tlvp_pkg::KIND_STRING;
							phase_n = PH_LEN_HI;
						end
						tlvp_pkg::TAG_BLOB: begin
							kind_n = tlvp_pkg::KIND_BLOB;
							phase_n = PH_LEN_HI;
						end
						default: begin
							result = status_only(tlvp_pkg::ST_BAD_TAG);
							have = 1'b1;
							err_n = 1'b1;
						end
					endcase
				end
				PH_LEN_HI: begin
					acc_n = {56'd0, b};
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					acc_n = {48'd0, acc_q[7:0], b};
					sstart_n = pos_q + 16'd1;
					rem_n = {acc_q[7:0], b};
					if (rem_n == 16'd0) begin
						phase_n = PH_TAG;
						do_finish = (kind_q == tlvp_pkg::KIND_STRING);
					end else begin
						phase_n = PH_BODY;
					end
				end
				PH_VALUE: begin
					acc_n = {acc_q[55:0], b};
					rem_n = rem_q - 16'd1;
					if (rem_n == 16'd0) begin
						phase_n = PH_TAG;
						do_finish = 1'b1;
					end
				end
				PH_BODY: begin
					rem_n = rem_q - 16'd1;
					if (rem_n == 16'd0) begin
						phase_n = PH_TAG;
						do_finish = (kind_q == tlvp_pkg::KIND_STRING);
					end
				end
			endcase

			// completed value or string
			if (do_finish) begin
				ptr_ok = (acc_n[31:0] >= tlvp_pkg::PTR_A_LO && acc_n[31:0] < tlvp_pkg::PTR_A_HI) ||
					(acc_n[31:0] >= tlvp_pkg::PTR_B_LO && acc_n[31:0] < tlvp_pkg::PTR_B_HI);
				have = 1'b1;
				if (kind_q == tlvp_pkg::KIND_PTR && !ptr_ok) begin
					result = status_only(tlvp_pkg::ST_BAD_PTR);
					err_n = 1'b1;
				end else if (slot >= CNT_MAX) begin
					result = status_only(tlvp_pkg::ST_TOO_MANY);
					err_n = 1'b1;
				end else begin
					cnt_n[kidx] = slot + CNT_W'(1);
					result.field_kind = kind_q;
					result.field_slot = 4'(slot);
					result.status = tlvp_pkg::ST_OK;
					if (kind_q == tlvp_pkg::KIND_STRING) begin
						result.string_offset = sstart_n;
						result.string_length = acc_n[15:0];
					end else begin
						result.field_value = acc_n;
					end
				end
			end

			// end of payload and length limit
			if (!err_n) begin
				if (item.end_of_payload) begin
					if (phase_n != PH_TAG) begin
						result = status_only(tlvp_pkg::ST_TRUNCATED);
						have = 1'b1;
						err_n = 1'b1;
					end else if (!have) begin
						result = status_only(tlvp_pkg::ST_OK);
						have = 1'b1;
					end else begin
						result.final_res = 1'b1;
					end
				end else if (pos_q == LAST_POS) begin
					result = status_only(tlvp_pkg::ST_TOO_LONG);
					have = 1'b1;
					err_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			kind_q <= tlvp_pkg::KIND_NONE;
			acc_q <= '0;
			rem_q <= '0;
			pos_q <= '0;
			sstart_q <= '0;
			err_q <= 1'b0;
			for (int i = 0; i < tlvp_pkg::NUM_KINDS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (step) begin
			if (item.end_of_payload) begin
				// back to the start for the next payload
				phase_q <= PH_TAG;
				kind_q <= tlvp_pkg::KIND_NONE;
				acc_q <= '0;
				rem_q <= '0;
				pos_q <= '0;
				sstart_q <= '0;
				err_q <= 1'b0;
				for (int i = 0; i < tlvp_pkg::NUM_KINDS; i++) begin
					cnt_q[i] <= '0;
				end
			end else begin
				phase_q <= phase_n;
				kind_q <= kind_n;
				acc_q <= acc_n;
				rem_q <= rem_n;
				pos_q <= pos_n;
				sstart_q <= sstart_n;
				err_q <= err_n;
				cnt_q <= cnt_n;
			end
		end
	end

endmodule

// ===== hw/rtl/tlvp_out_stage.sv =====
// result register toward the receiver
module tlvp_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   have,
	input  tlvp_pkg::field_item_t  result,
	output logic                   field_valid,
	input  logic                   field_ready,
	output tlvp_pkg::field_item_t  field_item,
	output logic                   free
);

	// can load when empty or when the held result leaves this cycle
	assign free = !field_valid || field_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_valid <= 1'b0;
		end else if (free) begin
			field_valid <= step && have;
		end
	end

	always_ff @(posedge clk) begin
		if (step && have) begin
			field_item <= result;
		end
	end

endmodule

// ===== hw/rtl/typed_parameter_stream_parser.sv =====
// top level of the typed parameter stream parser
//
// usage: payload bytes come in on the byte channel (byte_valid, byte_ready,
// byte_item), one request per byte, with end_of_payload set on the last one.
// results leave on the field channel (field_valid, field_ready, field_item):
// at most one per byte, for a finished int, float, double, pointer or string,
// for the end of the payload, or for the first error, which ends the parse.
// bytes after an error are swallowed without results up to the payload end.
// path: a byte taken into the input register is decoded into the result
// register, from which the receiver takes its result; the decode waits while
// the result register is full. throughput: one byte per cycle while results
// are taken, set by the single decode pass between the two registers; one
// more byte is taken while a result waits.
// when the receiver stalls, the result register holds and the input register
// fills, then byte_ready drops until the result is taken.
// reset: arst_n clears the valid flags of both registers, returns the parse
// state to tag expected and zeroes all counts, as each last byte also does.
module typed_parameter_stream_parser #(
	parameter int unsigned MAX_PER_KIND = tlvp_pkg::DEF_MAX_PER_KIND
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  tlvp_pkg::byte_item_t   byte_item,
	output logic                   field_valid,
	input  logic                   field_ready,
	output tlvp_pkg::field_item_t  field_item
);

	logic                  valid_s1;
	tlvp_pkg::byte_item_t  item_s1;
	logic                  out_free;
	logic                  step;
	logic                  have;
	tlvp_pkg::field_item_t result;

	// a held byte is decoded when the result register can take its result
	assign step = valid_s1 && out_free;

	// input register
	tlvp_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.take       (step),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// parse state and decode
	tlvp_parser #(
		.MAX_PER_KIND (MAX_PER_KIND)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result),
		.have   (have)
	);

	// result register
	tlvp_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.have        (have),
		.result      (result),
		.field_valid (field_valid),
		.field_ready (field_ready),
		.field_item  (field_item),
		.free        (out_free)
	);

endmodule
